/* rtl/tbfr_pkg.sv */
`timescale 1ns / 1ps

package tbfr_pkg;

    localparam int TILE_SLOTS = 34;
    localparam int SLOT_W     = $clog2(TILE_SLOTS);
    localparam int LOAD_W     = $clog2(TILE_SLOTS + 1);
    localparam int SLOT_CMP_W = SLOT_W + 1;
    localparam int TILE_W     = 18;

    localparam logic [14:0] LINE_KEEP = 15'h7BE0;
    localparam logic [14:0] LINE_TAKE = 15'h041F;
    localparam logic [14:0] FINE_Y_ONE = 15'h1000;
    localparam logic [4:0]  COARSE_Y_LAST = 5'd29;
    localparam logic [4:0]  COARSE_MAX = 5'd31;
    localparam logic [5:0]  PALETTE_PAGE = 6'h3F;

    typedef enum logic [2:0] {
        OP_NAME        = 3'd0,
        OP_ATTR        = 3'd1,
        OP_PAT_LO      = 3'd2,
        OP_PAT_HI      = 3'd3,
        OP_TILE_DONE   = 3'd4,
        OP_LINE_RESET  = 3'd5,
        OP_FRAME_RESET = 3'd6,
        OP_PIXEL       = 3'd7
    } tbfr_op_t;

    typedef enum logic [1:0] {
        CFG_PATTERN_SELECT = 2'd0,
        CFG_FINE_X         = 2'd1,
        CFG_SHOW_LEFT      = 2'd2
    } tbfr_cfg_idx_t;

    typedef struct packed {
        tbfr_op_t    op;
        logic [14:0] value;
        logic [7:0]  dot;
        logic        render_enabled;
    } tbfr_in_t;

    typedef struct packed {
        logic [13:0] fetch_address;
        logic        fetch_valid;
        logic [4:0]  pixel;
        logic        pixel_valid;
        logic [14:0] scroll_now;
    } tbfr_out_t;

    typedef struct packed {
        logic        pattern_table_select;
        logic [2:0]  fine_x;
        logic        show_left_column;
    } tbfr_cfg_t;

    typedef struct packed {
        logic [14:0]       scroll;
        logic [13:0]       latch;
        logic [LOAD_W-1:0] load_slot;
    } tbfr_state_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [TILE_W-1:0] data;
    } tbfr_wr_t;

endpackage

/* rtl/tile_background_fetch_render_core.sv */
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// in       in_valid / in_ready      in_data    (tbfr_in_t: op, value, dot, render_enabled)
// out      out_valid / out_ready    out_data   (tbfr_out_t: one result per item)
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
// Each item passes through the input register, where the tile store read data
// arrives, and then through the result register. One item is accepted every cycle
// while the result does not stall; the rate is set by the single write port of the
// tile store, which the current item writes as the next one is read.
// Reset clears scroll, latch, slot counter and the valid bits of the tile store.
// A stalled result holds the result register; the input register then holds too.

module tile_background_fetch_render_core
    import tbfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tbfr_in_t      in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tbfr_out_t     out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  tbfr_cfg_idx_t cfg_index,
    input  logic [2:0]    cfg_data
);

    tbfr_cfg_t         cfg_reg;
    tbfr_state_t       st_reg;
    tbfr_state_t       st_next;
    tbfr_wr_t          wr_step;
    tbfr_wr_t          wr;
    tbfr_out_t         res;
    tbfr_in_t          s0_item_reg;
    logic              s0_valid_reg;
    logic [2:0]        s0_pos_lo_reg;
    logic              s0_hit_reg;
    logic              out_valid_reg;
    tbfr_out_t         out_data_reg;
    logic              fire;
    logic              accept;
    logic [8:0]        pos;
    logic              pix_hit;
    logic [LOAD_W-1:0] slot_after;
    logic [TILE_W-1:0] tile_pix;
    logic [TILE_W-1:0] tile_old;

    assign fire      = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s0_valid_reg || fire;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pos        = {1'b0, in_data.dot} + {6'd0, cfg_reg.fine_x};
    assign pix_hit    = {1'b0, pos[8:3]} < 7'(TILE_SLOTS);
    assign slot_after = fire ? st_next.load_slot : st_reg.load_slot;

    always_comb
    begin
        wr    = wr_step;
        wr.en = wr_step.en && fire;
    end

    tbfr_tile_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (SLOT_W'(pos[8:3])),
        .rd_addr_b (slot_after[SLOT_W-1:0]),
        .wr        (wr),
        .rd_data_a (tile_pix),
        .rd_data_b (tile_old)
    );

    tbfr_step_logic u_step (
        .item     (s0_item_reg),
        .pos_lo   (s0_pos_lo_reg),
        .slot_hit (s0_hit_reg),
        .st       (st_reg),
        .cfg      (cfg_reg),
        .tile_pix (tile_pix),
        .tile_old (tile_old),
        .st_next  (st_next),
        .wr       (wr_step),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_table_select <= 1'b0;
            cfg_reg.fine_x               <= 3'd0;
            cfg_reg.show_left_column     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_SELECT: cfg_reg.pattern_table_select <= cfg_data[0];
                CFG_FINE_X:         cfg_reg.fine_x               <= cfg_data;
                CFG_SHOW_LEFT:      cfg_reg.show_left_column     <= cfg_data[0];
                default:            cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                st_reg <= st_next;
            end
            if (accept)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s0_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_item_reg   <= in_data;
            s0_pos_lo_reg <= pos[2:0];
            s0_hit_reg    <= pix_hit;
        end
        if (fire)
        begin
            out_data_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.load_slot <= LOAD_W'(TILE_SLOTS))
        else $error("slot counter ran past the tile store");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s0_item_reg.op == OP_TILE_DONE && st_reg.load_slot < LOAD_W'(TILE_SLOTS)
        |=> st_reg.load_slot == $past(st_reg.load_slot) + LOAD_W'(1))
        else $error("tile done did not advance the slot");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.fetch_valid && out_data_reg.pixel_valid))
        else $error("result is both a fetch and a pixel");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.fetch_valid && !out_data_reg.pixel_valid
        |-> out_data_reg.fetch_address == 14'd0 && out_data_reg.pixel == 5'd0)
        else $error("non-request result carries address or pixel");
`endif

endmodule

/* rtl/tbfr_tile_store.sv */
`timescale 1ns / 1ps

module tbfr_tile_store
    import tbfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr_a,
    input  logic [SLOT_W-1:0] rd_addr_b,
    input  tbfr_wr_t          wr,
    output logic [TILE_W-1:0] rd_data_a,
    output logic [TILE_W-1:0] rd_data_b
);

    logic [TILE_W-1:0]     mem [TILE_SLOTS];
    logic [TILE_SLOTS-1:0] vld_reg;
    logic [TILE_W-1:0]     data_a_reg;
    logic [TILE_W-1:0]     data_b_reg;
    logic                  ok_a_reg;
    logic                  ok_b_reg;
    logic                  in_a;
    logic                  in_b;
    logic                  byp_a;
    logic                  byp_b;

    // A read at the address being written this cycle takes the new data.
    assign in_a  = {1'b0, rd_addr_a} < SLOT_CMP_W'(TILE_SLOTS);
    assign in_b  = {1'b0, rd_addr_b} < SLOT_CMP_W'(TILE_SLOTS);
    assign byp_a = wr.en && (wr.addr == rd_addr_a);
    assign byp_b = wr.en && (wr.addr == rd_addr_b);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= byp_a ? wr.data : mem[rd_addr_a];
            data_b_reg <= byp_b ? wr.data : mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ok_a_reg <= 1'b0;
            ok_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                ok_a_reg <= in_a && (byp_a || vld_reg[rd_addr_a]);
                ok_b_reg <= in_b && (byp_b || vld_reg[rd_addr_b]);
            end
        end
    end

    assign rd_data_a = ok_a_reg ? data_a_reg : '0;
    assign rd_data_b = ok_b_reg ? data_b_reg : '0;

endmodule

/* rtl/tbfr_step_logic.sv */
`timescale 1ns / 1ps

module tbfr_step_logic
    import tbfr_pkg::*;
(
    input  tbfr_in_t          item,
    input  logic [2:0]        pos_lo,
    input  logic              slot_hit,
    input  tbfr_state_t       st,
    input  tbfr_cfg_t         cfg,
    input  logic [TILE_W-1:0] tile_pix,
    input  logic [TILE_W-1:0] tile_old,
    output tbfr_state_t       st_next,
    output tbfr_wr_t          wr,
    output tbfr_out_t         res
);

    logic [14:0]       v;
    logic [7:0]        rd_byte;
    logic              slot_open;
    logic [14:0]       line_v;
    logic [1:0]        attr_sel;
    logic [1:0]        attr_bits;
    logic [TILE_W-1:0] t;
    logic [2:0]        sh;
    logic [7:0]        t_lo;
    logic [7:0]        t_hi;
    logic [1:0]        col;

    assign v         = st.scroll;
    assign rd_byte   = item.value[7:0];
    assign slot_open = st.load_slot < LOAD_W'(TILE_SLOTS);
    assign attr_sel  = {v[6], v[1]};
    assign attr_bits = rd_byte[{attr_sel, 1'b0} +: 2];
    assign t         = slot_hit ? tile_pix : '0;
    assign sh        = ~pos_lo;
    assign t_lo      = t[7:0];
    assign t_hi      = t[15:8];
    assign col       = {t_hi[sh], t_lo[sh]};

    // Fine Y steps first; on its wrap coarse Y steps, and row 29 flips nametable Y.
    always_comb
    begin
        line_v = v + FINE_Y_ONE;
        if (line_v[14:12] == 3'd0)
        begin
            if (line_v[9:5] == COARSE_Y_LAST)
            begin
                line_v[9:5] = 5'd0;
                line_v[11]  = ~line_v[11];
            end
            else if (line_v[9:5] == COARSE_MAX)
            begin
                line_v[9:5] = 5'd0;
            end
            else
            begin
                line_v[9:5] = line_v[9:5] + 5'd1;
            end
        end
    end

    always_comb
    begin
        st_next = st;
        wr.en   = 1'b0;
        wr.addr = st.load_slot[SLOT_W-1:0];
        wr.data = tile_old;
        res     = '0;
        unique case (item.op)
            OP_NAME:
            begin
                res.fetch_address = {2'b10, v[11:0]};
                res.fetch_valid   = 1'b1;
            end
            OP_ATTR:
            begin
                st_next.latch = {1'b0, cfg.pattern_table_select, rd_byte, 1'b0, v[14:12]};
                res.fetch_address = {2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]};
                res.fetch_valid   = 1'b1;
            end
            OP_PAT_LO:
            begin
                wr.en   = slot_open;
                wr.data = {attr_bits, tile_old[15:0]};
                res.fetch_address = st.latch;
                res.fetch_valid   = 1'b1;
            end
            OP_PAT_HI:
            begin
                wr.en   = slot_open;
                wr.data = {tile_old[17:16], 8'h00, rd_byte};
                res.fetch_address = st.latch | 14'h0008;
                res.fetch_valid   = 1'b1;
            end
            OP_TILE_DONE:
            begin
                wr.en   = slot_open;
                wr.data = tile_old | {2'b00, rd_byte, 8'h00};
                if (slot_open)
                begin
                    st_next.load_slot = st.load_slot + LOAD_W'(1);
                end
                if (v[4:0] == COARSE_MAX)
                begin
                    st_next.scroll[4:0] = 5'd0;
                    st_next.scroll[10]  = ~v[10];
                end
                else
                begin
                    st_next.scroll[4:0] = v[4:0] + 5'd1;
                end
            end
            OP_LINE_RESET:
            begin
                st_next.scroll    = (line_v & LINE_KEEP) | (item.value & LINE_TAKE);
                st_next.load_slot = '0;
            end
            OP_FRAME_RESET:
            begin
                st_next.scroll = (v & LINE_TAKE) | (item.value & LINE_KEEP);
            end
            OP_PIXEL:
            begin
                res.pixel_valid = 1'b1;
                if (!item.render_enabled)
                begin
                    if (v[13:8] == PALETTE_PAGE)
                    begin
                        res.pixel = v[4:0];
                    end
                end
                else if (!(item.dot < 8'd8 && !cfg.show_left_column))
                begin
                    res.pixel = (col != 2'b00) ? {1'b0, t[17:16], col} : 5'd0;
                end
            end
        endcase
        res.scroll_now = st_next.scroll;
    end

endmodule
